FILE: hw/rtl/aes128v_pkg.sv
// Shared constants, tables and byte functions for the AES-128 variant cipher.
package aes128v_pkg;

  localparam int NumRounds = 10;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;
  typedef byte_t box_t [256];

  localparam byte_t RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                  8'h20, 8'h40, 8'h80, 8'h4d, 8'h9a};

  function automatic byte_t rot8(byte_t v, int s);
    return byte_t'((v << s) | (v >> (8 - s)));
  endfunction

  function automatic byte_t gf_dbl(byte_t v);
    return byte_t'({v[6:0], 1'b0} ^ (v[7] ? 8'h4d : 8'h00));
  endfunction

  function automatic byte_t gf_mul(byte_t v, logic [3:0] c);
    byte_t acc;
    byte_t x;
    acc = '0;
    x = v;
    for (int b = 0; b < 4; b++) begin
      if (c[b]) acc = acc ^ x;
      x = gf_dbl(x);
    end
    return acc;
  endfunction

  // Power walk over the field; evaluated at elaboration only.
  function automatic box_t build_fwd();
    box_t t;
    byte_t p;
    byte_t q;
    logic done;
    for (int i = 0; i < 256; i++) t[i] = '0;
    p = 8'h01;
    q = 8'h01;
    done = 1'b0;
    for (int n = 0; n < 256; n++) begin
      if (!done) begin
        p = p ^ byte_t'({p[6:0], 1'b0}) ^ (p[7] ? 8'h4d : 8'h00);
        q = q ^ byte_t'({q[6:0], 1'b0});
        q = q ^ byte_t'({q[5:0], 2'b0});
        q = q ^ byte_t'({q[3:0], 4'b0});
        if (q[7]) q = q ^ 8'h3b;
        t[p] = q ^ rot8(q, 1) ^ rot8(q, 2) ^ rot8(q, 3) ^ rot8(q, 4) ^ 8'h15;
        if (p == 8'h01) done = 1'b1;
      end
    end
    t[0] = 8'h15;
    return t;
  endfunction

  function automatic box_t build_inv(box_t f);
    box_t t;
    for (int i = 0; i < 256; i++) t[i] = '0;
    for (int i = 0; i < 256; i++) t[f[i]] = byte_t'(i);
    return t;
  endfunction

  localparam box_t FWD_BOX = build_fwd();
  localparam box_t INV_BOX = build_inv(FWD_BOX);

  // Byte i of the state sits at bits 127-8i downto 120-8i.
  function automatic byte_t get_b(blk_t s, int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] col, logic dec);
    logic [3:0] m [4];
    byte_t c [4];
    byte_t acc;
    logic [31:0] res;
    if (dec) m = '{4'he, 4'hb, 4'hd, 4'h9};
    else     m = '{4'h2, 4'h3, 4'h1, 4'h1};
    for (int j = 0; j < 4; j++) c[j] = col[31 - 8 * j -: 8];
    res = '0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) acc = acc ^ gf_mul(c[j], m[(j + 4 - r) % 4]);
      res[31 - 8 * r -: 8] = acc;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/aes128_variant_block_cipher_top.sv
// From accepted word to result: the key add stage plus ten round stages, each registered.
// Throughput: one block per cycle while the expander is not busy; the whole pipe advances when the output is free.
// After reset or a key write the expander builds the round keys one at a time,
// holding s_axis_tready low meanwhile. Reset keys are all zero.
// Reset is synchronous, active high, and clears all valid bits.
module aes128_variant_block_cipher_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_high[63:0], block_low[127:64]
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // result_high[63:0], result_low[127:64]
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);
  import aes128v_pkg::*;

  blk_t rk [11];
  logic busy;
  logic en;
  logic v [11];
  logic md [11];
  blk_t st [11];
  blk_t in_blk;

  aes128v_keyexp u_keyexp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .busy(busy), .rk(rk)
  );

  assign en = !v[10] || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign in_blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  // initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid && !busy;
    end
    if (en) begin
      md[0] <= s_axis_tuser;
      st[0] <= in_blk ^ (s_axis_tuser ? rk[10] : rk[0]);
    end
  end

  for (genvar i = 1; i <= 10; i++) begin : g_rnd
    aes128v_round #(.LAST(i == 10)) u_round (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i-1]), .in_mode(md[i-1]), .in_state(st[i-1]),
      .enc_key(rk[i]), .dec_key(rk[10-i]),
      .out_valid(v[i]), .out_mode(md[i]), .out_state(st[i])
    );
  end

  assign m_axis_tvalid = v[10];
  assign m_axis_tdata  = {st[10][63:0], st[10][127:64]};
endmodule

FILE: hw/rtl/aes128v_keyexp.sv
// Iterative round key expansion, one round key per cycle after reset or a key write.
module aes128v_keyexp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data,
  output logic                 busy,
  output aes128v_pkg::blk_t    rk [11]
);
  import aes128v_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [3:0]  cnt;
  blk_t        prev;
  blk_t        nxt;
  logic [31:0] t;
  logic [31:0] w4, w5, w6, w7;

  always_comb begin
    t = {FWD_BOX[prev[23:16]], FWD_BOX[prev[15:8]], FWD_BOX[prev[7:0]],
         FWD_BOX[prev[31:24]]};
    t[31:24] = t[31:24] ^ RCON[cnt[3:0] - 4'd1];
    w4 = prev[127:96] ^ t;
    w5 = prev[95:64] ^ w4;
    w6 = prev[63:32] ^ w5;
    w7 = prev[31:0] ^ w6;
    nxt = {w4, w5, w6, w7};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      busy     <= 1'b1;
      cnt      <= '0;
    end else if (cfg_we) begin
      if (cfg_index) key_low <= cfg_data;
      else           key_high <= cfg_data;
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == 4'd0) begin
        rk[0] <= {key_high, key_low};
        prev  <= {key_high, key_low};
      end else begin
        rk[cnt] <= nxt;
        prev    <= nxt;
      end
      if (cnt == 4'(NumRounds)) busy <= 1'b0;
      cnt <= cnt + 4'd1;
    end
  end
endmodule

FILE: hw/rtl/aes128v_round.sv
// One registered cipher round, encrypt or decrypt chosen per word.
module aes128v_round #(
  parameter bit LAST = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               in_mode,
  input  aes128v_pkg::blk_t  in_state,
  input  aes128v_pkg::blk_t  enc_key,
  input  aes128v_pkg::blk_t  dec_key,
  output logic               out_valid,
  output logic               out_mode,
  output aes128v_pkg::blk_t  out_state
);
  import aes128v_pkg::*;

  blk_t e_sh, e_mx, d_sh, d_ak, d_mx, res;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        e_sh[127 - 8 * (c * 4 + r) -: 8] =
          FWD_BOX[get_b(in_state, ((c + r) % 4) * 4 + r)];
        d_sh[127 - 8 * (c * 4 + r) -: 8] =
          INV_BOX[get_b(in_state, ((c + 4 - r) % 4) * 4 + r)];
      end
    end
    d_ak = d_sh ^ dec_key;
    for (int c = 0; c < 4; c++) begin
      e_mx[127 - 32 * c -: 32] = mix_col(e_sh[127 - 32 * c -: 32], 1'b0);
      d_mx[127 - 32 * c -: 32] = mix_col(d_ak[127 - 32 * c -: 32], 1'b1);
    end
    if (in_mode) res = LAST ? d_ak : d_mx;
    else         res = (LAST ? e_sh : e_mx) ^ enc_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_mode  <= in_mode;
      out_state <= res;
    end
  end
endmodule
